[hdl/blfs_pkg.sv]
// ----------------------------------------------------------------------------
// blfs_pkg
// shared types and constants of the bit-plane led frame store
// ----------------------------------------------------------------------------
package blfs_pkg;

    localparam int LED_COUNT = 256;
    localparam int CHANNELS  = 32;

    localparam int WORD_W    = 32;
    localparam int BUF_WORDS = WORD_W * LED_COUNT;
    localparam int BUF_AW    = $clog2(BUF_WORDS);
    localparam int ADDR_W    = BUF_AW + 1;
    localparam int MEM_DEPTH = 2 * BUF_WORDS;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_FLIP  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        FMT_RGB  = 2'd0,
        FMT_GRB  = 2'd1,
        FMT_GRBW = 2'd2,
        FMT_BAD  = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        CMD_RESULT = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               ok;
        logic [ADDR_W-1:0]  base;
        logic [4:0]         ch;
        logic               grb;
        logic               grbw;
        logic [WORD_W-1:0]  val;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_RUN   = 3'd2,
        ST_DRAIN = 3'd3,
        ST_DONE  = 3'd4
    } back_state_t;

endpackage

[hdl/blfs_front.sv]
// ----------------------------------------------------------------------------
// blfs_front
// accepts items, holds the format register and buffer select, builds commands
// ----------------------------------------------------------------------------
module blfs_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [63:0]             cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // channel, led_index, red, green, blue, white, to_inactive, zero pad
    input  logic [47:0]             s_axis_tdata,
    // func
    input  logic [1:0]              s_axis_tuser,
    input  blfs_pkg::back_status_t  status,
    output logic                    push_valid,
    input  logic                    push_ready,
    output blfs_pkg::cmd_t          push_data
);
    import blfs_pkg::*;

    logic [63:0]       formats_reg;
    logic [63:0]       formats_next;
    logic              active_reg;
    logic              active_next;

    func_t             func;
    logic [4:0]        ch;
    logic [7:0]        led;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        white;
    logic              to_inactive;
    fmt_t              fmt;
    logic              in_range;
    logic [BUF_AW-1:0] led_base;
    logic              buf_sel;
    logic              accept;

    assign func        = func_t'(s_axis_tuser);
    assign ch          = s_axis_tdata[4:0];
    assign led         = s_axis_tdata[12:5];
    assign red         = s_axis_tdata[20:13];
    assign green       = s_axis_tdata[28:21];
    assign blue        = s_axis_tdata[36:29];
    assign white       = s_axis_tdata[44:37];
    assign to_inactive = s_axis_tdata[45];

    assign push_valid    = s_axis_tvalid && !status.clearing;
    assign s_axis_tready = push_ready && !status.clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        fmt      = fmt_t'(formats_reg[{ch, 1'b0} +: 2]);
        in_range = (32'(led) < LED_COUNT) && (32'(ch) < CHANNELS);
        if (fmt == FMT_GRBW)
        begin
            led_base = BUF_AW'({led, 5'b0});
        end
        else
        begin
            led_base = BUF_AW'({led, 4'b0}) + BUF_AW'({led, 3'b0});
        end
        buf_sel = (func == FUNC_WRITE) ? (active_reg ^ to_inactive) : active_reg;

        push_data.ch   = ch;
        push_data.grb  = (fmt != FMT_RGB);
        push_data.grbw = (fmt == FMT_GRBW);
        push_data.base = {buf_sel, led_base};
        push_data.ok   = 1'b0;
        push_data.kind = CMD_RESULT;
        unique case (fmt)
            FMT_RGB:  push_data.val = {red, green, blue, 8'h00};
            FMT_GRB:  push_data.val = {green, red, blue, 8'h00};
            FMT_GRBW: push_data.val = {green, red, blue, white};
            default:  push_data.val = '0;
        endcase

        active_next = active_reg;
        unique case (func)
            FUNC_WRITE:
            begin
                if (in_range && fmt != FMT_BAD)
                begin
                    push_data.kind = CMD_WRITE;
                    push_data.ok   = 1'b1;
                end
            end
            FUNC_READ:
            begin
                if (in_range && fmt != FMT_BAD)
                begin
                    push_data.kind = CMD_READ;
                    push_data.ok   = 1'b1;
                end
            end
            FUNC_FLIP:
            begin
                push_data.ok = 1'b1;
                if (accept)
                begin
                    active_next = ~active_reg;
                end
            end
            default:
            begin
                push_data.ok = 1'b0;
            end
        endcase

        formats_next = cfg_we ? cfg_wdata : formats_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            formats_reg <= '0;
            active_reg  <= 1'b0;
        end
        else
        begin
            formats_reg <= formats_next;
            active_reg  <= active_next;
        end
    end

endmodule

[hdl/blfs_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// blfs_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module blfs_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  blfs_pkg::cmd_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output blfs_pkg::cmd_t  pop_data
);
    import blfs_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/blfs_back.sv]
// ----------------------------------------------------------------------------
// blfs_back
// bit-plane memory with clearing pass and read-modify-write sequencer
// ----------------------------------------------------------------------------
module blfs_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  blfs_pkg::cmd_t          pop_data,
    output blfs_pkg::back_status_t  status,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // red, green, blue, white
    output logic [31:0]             m_axis_tdata,
    // ok
    output logic                    m_axis_tuser
);
    import blfs_pkg::*;

    logic [WORD_W-1:0] mem [MEM_DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [4:0]        idx_reg;
    logic [4:0]        idx_next;
    logic [WORD_W-1:0] shift_reg;
    logic [WORD_W-1:0] shift_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [ADDR_W-1:0] pend_addr_next;
    logic              pend_bit_reg;
    logic              pend_bit_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [31:0]       out_data_reg;
    logic [31:0]       out_data_next;
    logic              out_ok_reg;
    logic              out_ok_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mask;
    logic [4:0]        last_idx;
    logic [WORD_W-1:0] val;
    logic [7:0]        red;
    logic [7:0]        green;

    assign status.clearing = (state_reg == ST_CLEAR);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser    = out_ok_reg;

    assign mask      = WORD_W'(1) << cmd_reg.ch;
    assign last_idx  = cmd_reg.grbw ? 5'd31 : 5'd23;
    assign mem_raddr = cmd_reg.base + ADDR_W'(idx_reg);

    always_comb
    begin
        val   = cmd_reg.grbw ? shift_reg : {shift_reg[23:0], 8'h00};
        red   = cmd_reg.grb ? val[23:16] : val[31:24];
        green = cmd_reg.grb ? val[31:24] : val[23:16];
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        shift_next      = shift_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_bit_next   = pend_bit_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_ok_next     = out_ok_reg;
        pop_ready       = 1'b0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = pend_bit_reg ? (rdata_reg | mask) : (rdata_reg & ~mask);

        // complete the word read in the previous cycle
        if (pend_valid_reg)
        begin
            if (cmd_reg.kind == CMD_WRITE)
            begin
                mem_we = 1'b1;
            end
            else
            begin
                shift_next = {shift_reg[WORD_W-2:0], |(rdata_reg & mask)};
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    cmd_next = pop_data;
                    idx_next = '0;
                    if (pop_data.kind == CMD_RESULT)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        shift_next = (pop_data.kind == CMD_WRITE) ? pop_data.val : '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                mem_re          = 1'b1;
                pend_valid_next = 1'b1;
                pend_addr_next  = mem_raddr;
                if (cmd_reg.kind == CMD_WRITE)
                begin
                    pend_bit_next = shift_reg[WORD_W-1];
                    shift_next    = {shift_reg[WORD_W-2:0], 1'b0};
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = cmd_reg.ok;
                    out_data_next  = '0;
                    if (cmd_reg.kind == CMD_READ)
                    begin
                        out_data_next = {(cmd_reg.grbw ? val[7:0] : 8'h00),
                                         val[15:8], green, red};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        shift_reg     <= shift_next;
        pend_addr_reg <= pend_addr_next;
        pend_bit_reg  <= pend_bit_next;
        out_data_reg  <= out_data_next;
        out_ok_reg    <= out_ok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_no_same_addr_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same word in one cycle");

    a_drain_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> pend_valid_reg)
        else $error("drain without a pending word");

    a_clear_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg && !pend_valid_reg)
        else $error("activity during clearing pass");

    a_run_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (idx_reg <= last_idx))
        else $error("bit index past end of led");
`endif

endmodule

[hdl/bitplane_led_frame_store.sv]
// ----------------------------------------------------------------------------
// bitplane_led_frame_store
// double-buffered bit-transposed frame store for parallel led strips
// write and read: one memory word read per colour bit, 24 bits (rgb, grb) or
//   32 bits (grbw), and written back with the bit changed for a write
// items are queued while the back is busy; the back takes one command at a time
// reset: a clearing pass zeroes all 16384 memory words, no item taken
// ----------------------------------------------------------------------------
module bitplane_led_frame_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // channel, led_index, red_in, green_in, blue_in, white_in, to_inactive, pad
    input  logic [47:0] s_axis_tdata,
    // func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red_out, green_out, blue_out, white_out
    output logic [31:0] m_axis_tdata,
    // ok
    output logic        m_axis_tuser
);
    import blfs_pkg::*;

    logic         push_valid;
    logic         push_ready;
    cmd_t         push_data;
    logic         pop_valid;
    logic         pop_ready;
    cmd_t         pop_data;
    back_status_t status;

    blfs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .status        (status),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    blfs_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    blfs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
